// File: rtl/core/tfn_pkg.sv
// Shared widths and the per-stage record of the triangle face normal pipeline.
`default_nettype none
package tfn_pkg;

    localparam int COORD_W    = 16;
    localparam int IN_W       = 9 * COORD_W;
    localparam int EDGE_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * EDGE_W;
    localparam int CROSS_W    = PROD_W + 1;
    localparam int MAG_W      = CROSS_W - 1;
    localparam int HALF_W     = MAG_W / 2;
    localparam int PART_W     = 2 * HALF_W;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int LEN_W      = SQ_W + 2;
    localparam int K_W        = 15;
    localparam int STEP_CNT   = K_W;
    localparam int FRAC_SHIFT = 28;
    localparam int P_W        = LEN_W + K_W;
    localparam int REM_W      = P_W + K_W + 2;
    localparam int OUT_W      = 16;

    // Cross product, one signed component per lane.
    typedef struct packed {
        logic signed [CROSS_W-1:0] nx;
        logic signed [CROSS_W-1:0] ny;
        logic signed [CROSS_W-1:0] nz;
    } cross_t;

    // State of the digit-by-digit quotient search for all three lanes.
    typedef struct packed {
        logic                       degen;
        logic [2:0]                 neg;
        logic [LEN_W-1:0]           len2;
        logic [2:0][REM_W-1:0]      rem;
        logic [2:0][P_W-1:0]        prod;
        logic [2:0][K_W-1:0]        k;
    } iter_t;

endpackage
`default_nettype wire

// File: rtl/core/tfn_cross.sv
// Edge vectors, partial products and cross product in three register stages.
`default_nettype none
module tfn_cross
    import tfn_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire logic [IN_W-1:0] in_data,
    output logic                 out_valid,
    output cross_t               out_cross
);

    logic signed [COORD_W-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    logic signed [EDGE_W-1:0]  ux_reg, uy_reg, uz_reg, vx_reg, vy_reg, vz_reg;
    logic signed [PROD_W-1:0]  p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    cross_t                    cross_reg;
    logic [2:0]                valid_reg;

    assign ax = in_data[0*COORD_W +: COORD_W];
    assign ay = in_data[1*COORD_W +: COORD_W];
    assign az = in_data[2*COORD_W +: COORD_W];
    assign bx = in_data[3*COORD_W +: COORD_W];
    assign by = in_data[4*COORD_W +: COORD_W];
    assign bz = in_data[5*COORD_W +: COORD_W];
    assign cx = in_data[6*COORD_W +: COORD_W];
    assign cy = in_data[7*COORD_W +: COORD_W];
    assign cz = in_data[8*COORD_W +: COORD_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ux_reg <= EDGE_W'(bx) - EDGE_W'(ax);
            uy_reg <= EDGE_W'(by) - EDGE_W'(ay);
            uz_reg <= EDGE_W'(bz) - EDGE_W'(az);
            vx_reg <= EDGE_W'(cx) - EDGE_W'(ax);
            vy_reg <= EDGE_W'(cy) - EDGE_W'(ay);
            vz_reg <= EDGE_W'(cz) - EDGE_W'(az);
            p0_reg <= uy_reg * vz_reg;
            p1_reg <= uz_reg * vy_reg;
            p2_reg <= uz_reg * vx_reg;
            p3_reg <= ux_reg * vz_reg;
            p4_reg <= ux_reg * vy_reg;
            p5_reg <= uy_reg * vx_reg;
            cross_reg.nx <= CROSS_W'(p0_reg) - CROSS_W'(p1_reg);
            cross_reg.ny <= CROSS_W'(p2_reg) - CROSS_W'(p3_reg);
            cross_reg.nz <= CROSS_W'(p4_reg) - CROSS_W'(p5_reg);
        end
    end

    assign out_valid = valid_reg[2];
    assign out_cross = cross_reg;

endmodule
`default_nettype wire

// File: rtl/core/tfn_square.sv
// Magnitudes, split squares, squared length and search set-up in three stages.
`default_nettype none
module tfn_square
    import tfn_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   en,
    input  wire logic   in_valid,
    input  wire cross_t in_cross,
    output logic        out_valid,
    output iter_t       out_iter
);

    logic [2:0][CROSS_W-1:0] comp;
    logic [2:0][MAG_W-1:0]   mag;
    logic [2:0]              neg_a_reg, neg_b_reg;
    logic [2:0][PART_W-1:0]  hh_reg, hl_reg, ll_reg;
    logic [2:0][SQ_W-1:0]    sq_reg;
    logic [LEN_W-1:0]        len2;
    iter_t                   iter_reg;
    logic [2:0]              valid_reg;

    assign comp[0] = in_cross.nx;
    assign comp[1] = in_cross.ny;
    assign comp[2] = in_cross.nz;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = comp[i][CROSS_W-1] ? MAG_W'(~comp[i] + 1'b1) : MAG_W'(comp[i]);
        end
    end

    assign len2 = LEN_W'(sq_reg[0]) + LEN_W'(sq_reg[1]) + LEN_W'(sq_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    // The 68-bit square is built from three half-width products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                neg_a_reg[i] <= comp[i][CROSS_W-1];
                hh_reg[i] <= PART_W'(mag[i][MAG_W-1:HALF_W]) * PART_W'(mag[i][MAG_W-1:HALF_W]);
                hl_reg[i] <= PART_W'(mag[i][MAG_W-1:HALF_W]) * PART_W'(mag[i][HALF_W-1:0]);
                ll_reg[i] <= PART_W'(mag[i][HALF_W-1:0]) * PART_W'(mag[i][HALF_W-1:0]);
                sq_reg[i] <= (SQ_W'(hh_reg[i]) << (2 * HALF_W))
                           + (SQ_W'(hl_reg[i]) << (HALF_W + 1))
                           + SQ_W'(ll_reg[i]);
                iter_reg.rem[i]  <= REM_W'(sq_reg[i]) << FRAC_SHIFT;
                iter_reg.prod[i] <= '0;
                iter_reg.k[i]    <= '0;
            end
            neg_b_reg      <= neg_a_reg;
            iter_reg.neg   <= neg_b_reg;
            iter_reg.len2  <= len2;
            iter_reg.degen <= (len2 == '0);
        end
    end

    assign out_valid = valid_reg[2];
    assign out_iter  = iter_reg;

endmodule
`default_nettype wire

// File: rtl/core/tfn_root_step.sv
// One quotient bit of the normalizing search for all three lanes.
`default_nettype none
module tfn_root_step
    import tfn_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire logic  in_valid,
    input  wire iter_t in_iter,
    output logic       out_valid,
    output iter_t      out_iter
);

    iter_t                 iter_next;
    iter_t                 iter_reg;
    logic [2:0][REM_W-1:0] trial;
    logic                  valid_reg;

    // rem holds c*c*2^28 - k*k*len2 and prod holds k*len2, so setting this bit
    // costs (prod << (BIT+1)) + (len2 << 2*BIT) and no multiplier is needed.
    always_comb
    begin
        iter_next = in_iter;
        for (int i = 0; i < 3; i++)
        begin
            trial[i] = (REM_W'(in_iter.prod[i]) << (BIT + 1))
                     + (REM_W'(in_iter.len2) << (2 * BIT));
            if (in_iter.rem[i] >= trial[i])
            begin
                iter_next.rem[i]  = in_iter.rem[i] - trial[i];
                iter_next.prod[i] = in_iter.prod[i] + (P_W'(in_iter.len2) << BIT);
                iter_next.k[i]    = in_iter.k[i] | (K_W'(1) << BIT);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            iter_reg <= iter_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_iter  = iter_reg;

endmodule
`default_nettype wire

// File: rtl/core/triangle_face_normal_core.sv
// Top level of the triangle face normal pipeline.
// A request runs through the cross, square and quotient bit stages and the output register.
// Throughput: one request per cycle unless stalled; 15 quotient bits in 15 pipeline stages.
// A stalled output holds the whole pipeline in place, so nothing is lost or repeated.
// Reset (rst_n low, asynchronous) clears all valid bits; data registers are not reset.
`default_nettype none
module triangle_face_normal_core
    import tfn_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [IN_W-1:0]     s_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [3*OUT_W-1:0]       m_tdata,   // normal_x, normal_y, normal_z
    output logic [0:0]               m_tuser    // degenerate
);

    logic                  en;
    logic                  cross_valid;
    cross_t                cross_data;
    logic [STEP_CNT:0]     stage_valid;
    iter_t                 stage_data [STEP_CNT+1];
    iter_t                 last;
    logic [2:0][OUT_W-1:0] normal;
    logic                  out_valid_reg;
    logic [3*OUT_W-1:0]    out_data_reg;
    logic                  out_degen_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    tfn_cross u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .out_valid (cross_valid),
        .out_cross (cross_data)
    );

    tfn_square u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cross_valid),
        .in_cross  (cross_data),
        .out_valid (stage_valid[0]),
        .out_iter  (stage_data[0])
    );

    for (genvar g = 0; g < STEP_CNT; g++)
    begin : g_step
        tfn_root_step #(
            .BIT (STEP_CNT - 1 - g)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (stage_valid[g]),
            .in_iter   (stage_data[g]),
            .out_valid (stage_valid[g+1]),
            .out_iter  (stage_data[g+1])
        );
    end

    assign last = stage_data[STEP_CNT];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (last.degen)
            begin
                normal[i] = '0;
            end
            else if (last.neg[i])
            begin
                normal[i] = OUT_W'(~OUT_W'(last.k[i]) + 1'b1);
            end
            else
            begin
                normal[i] = OUT_W'(last.k[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= stage_valid[STEP_CNT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg  <= {normal[2], normal[1], normal[0]};
            out_degen_reg <= last.degen;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_degen_reg;

`ifndef SYNTHESIS
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("degenerate result carries a nonzero normal");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[15:14] != 2'b10) && (m_tdata[31:30] != 2'b10)
                      && (m_tdata[47:46] != 2'b10)))
        else $error("normal component outside the unit range");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("request accepted while the pipeline is stalled");

    a_pipe_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tready && stage_valid[STEP_CNT]) |=> m_tvalid)
        else $error("result lost at the output register");
`endif

endmodule
`default_nettype wire
